// ===== rtl/core/psrb_pkg.sv =====
// psrb_pkg: types and constants for the per-sender rate blacklist
// no dependencies
`timescale 1ns / 1ps

package psrb_pkg;

    localparam int BUCKETS       = 256;
    localparam int WAYS          = 4;
    localparam int HISTORY_DEPTH = 64;
    localparam int SLOTS         = BUCKETS * WAYS;
    localparam int BUCKET_W      = $clog2(BUCKETS);
    localparam int WAY_W         = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int POS_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W        = 7;
    localparam int RING_AW       = SLOT_W + POS_W;

    localparam logic [30:0] WINDOW_RESET    = 31'd2000;
    localparam logic [6:0]  THRESHOLD_RESET = 7'd50;

    localparam logic [0:0] REG_WINDOW    = 1'b0;
    localparam logic [0:0] REG_THRESHOLD = 1'b1;

    localparam logic [1:0] V_NEW     = 2'd0;
    localparam logic [1:0] V_WHITE   = 2'd1;
    localparam logic [1:0] V_BLOCKED = 2'd2;
    localparam logic [1:0] V_FULL    = 2'd3;

    typedef struct packed {
        logic [30:0] sender_id;
        logic [15:0] time_step;
    } req_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [6:0] window_count;
        logic       changed_list;
    } res_t;

    // per-slot metadata word
    typedef struct packed {
        logic              valid;
        logic [30:0]       sender;
        logic              blocked;
        logic [POS_W-1:0]  head;
        logic [FILL_W-1:0] fill;
    } meta_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MATCH,
        S_PUSH,
        S_RREAD,
        S_RCHK,
        S_DONE,
        S_CLEAR
    } state_t;

endpackage

// ===== rtl/core/per_sender_rate_blacklist.sv =====
// per_sender_rate_blacklist: hashed sender table with per-slot timestamp rings
// depends on psrb_pkg
`timescale 1ns / 1ps
//
//  channel | signals                         | handshake
//  request | start, busy, req                | accepted when start && !busy
//  result  | done, res                       | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
//  each request reads the ways of its bucket one way at a time, pushes the
//  stamp, then checks ring stamps one read at a time (retired + 1 checks for
//  a known sender) and finishes in the done state. busy is high in every
//  state but idle; the result strobe follows with busy low.
//  after reset a clearing pass writes all SLOTS (1024) metadata words, busy high.
//  the result strobe cannot be held off; busy stays high until it is sent.

module per_sender_rate_blacklist (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  psrb_pkg::req_t      req,
    output logic                done,
    output psrb_pkg::res_t      res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [30:0]         cfg_data
);

    logic [30:0] window_reg;
    logic [6:0]  thresh_reg;
    logic [31:0] clock_reg;
    logic [psrb_pkg::SLOT_W-1:0] clr_reg;

    psrb_pkg::meta_t meta_mem [psrb_pkg::SLOTS];
    logic [31:0]     ring_mem [1 << psrb_pkg::RING_AW];

    psrb_pkg::state_t state_reg, state_next;
    logic [30:0]     id_reg;
    logic [psrb_pkg::WAY_W:0] way_reg;
    logic [psrb_pkg::SLOT_W-1:0] slot_reg;
    logic            found_reg, free_ok_reg;
    psrb_pkg::meta_t cur_reg, meta_rd, meta_wr;
    logic [31:0]     ring_rd;
    logic            is_new_reg;

    logic [psrb_pkg::SLOT_W-1:0] look_addr;
    logic [psrb_pkg::SLOT_W-1:0] first_slot;
    logic [psrb_pkg::POS_W-1:0]  push_pos;
    logic                        hit;
    logic                        expired;

    logic [6:0] cnt;
    logic       chg, blk_new;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != psrb_pkg::S_IDLE);

    assign first_slot = psrb_pkg::SLOT_W'(id_reg[psrb_pkg::BUCKET_W-1:0] * psrb_pkg::WAYS);
    assign look_addr  = first_slot + psrb_pkg::SLOT_W'(way_reg);
    assign hit        = meta_rd.valid && (meta_rd.sender == id_reg);
    assign expired    = (clock_reg - ring_rd) > {1'b0, window_reg};

    function automatic logic [psrb_pkg::POS_W-1:0] pos_add(
        input logic [psrb_pkg::POS_W-1:0] h, input logic [psrb_pkg::FILL_W-1:0] o);
        logic [psrb_pkg::FILL_W:0] p;
        begin
            p = {1'b0, o} + (psrb_pkg::FILL_W + 1)'(h);
            if (p >= (psrb_pkg::FILL_W + 1)'(psrb_pkg::HISTORY_DEPTH))
                p = p - (psrb_pkg::FILL_W + 1)'(psrb_pkg::HISTORY_DEPTH);
            pos_add = p[psrb_pkg::POS_W-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= psrb_pkg::WINDOW_RESET;
            thresh_reg <= psrb_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psrb_pkg::REG_WINDOW:    window_reg <= cfg_data;
                psrb_pkg::REG_THRESHOLD: thresh_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psrb_pkg::S_IDLE:  if (start) state_next = psrb_pkg::S_LOOK;
            psrb_pkg::S_LOOK:  state_next = psrb_pkg::S_MATCH;
            psrb_pkg::S_MATCH:
                if (hit)
                    state_next = psrb_pkg::S_PUSH;
                else if (way_reg == (psrb_pkg::WAY_W + 1)'(psrb_pkg::WAYS - 1))
                    state_next = psrb_pkg::S_PUSH;
                else
                    state_next = psrb_pkg::S_LOOK;
            psrb_pkg::S_PUSH:
                state_next = (found_reg) ? psrb_pkg::S_RREAD : psrb_pkg::S_DONE;
            psrb_pkg::S_RREAD: state_next = psrb_pkg::S_RCHK;
            psrb_pkg::S_RCHK:
                state_next = expired ? psrb_pkg::S_RREAD : psrb_pkg::S_DONE;
            psrb_pkg::S_DONE:  state_next = psrb_pkg::S_IDLE;
            psrb_pkg::S_CLEAR:
                if (clr_reg == psrb_pkg::SLOT_W'(psrb_pkg::SLOTS - 1))
                    state_next = psrb_pkg::S_IDLE;
            default:           state_next = psrb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psrb_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    // ring slot for the new stamp: oldest when full, position 0 for a new sender, else after the newest
    always_comb
    begin
        if (!found_reg)
            push_pos = '0;
        else if (cur_reg.fill >= psrb_pkg::FILL_W'(psrb_pkg::HISTORY_DEPTH))
            push_pos = cur_reg.head;
        else
            push_pos = pos_add(cur_reg.head, cur_reg.fill);
    end

    always_comb
    begin
        cnt = cur_reg.fill;
        chg = 1'b0;
        blk_new = cur_reg.blocked;
        if (!cur_reg.blocked && cnt >= thresh_reg)
        begin
            blk_new = 1'b1;
            chg = 1'b1;
        end
        else if (cur_reg.blocked && cnt < thresh_reg)
        begin
            blk_new = 1'b0;
            chg = 1'b1;
        end
    end

    // new senders start white with no threshold check
    always_comb
    begin
        meta_wr = cur_reg;
        if (found_reg)
            meta_wr.blocked = blk_new;
    end

    // memories, read data registered
    always_ff @(posedge clk)
    begin
        meta_rd <= meta_mem[look_addr];
        ring_rd <= ring_mem[{slot_reg, cur_reg.head}];
        if (state_reg == psrb_pkg::S_PUSH && (found_reg || free_ok_reg))
            ring_mem[{slot_reg, push_pos}] <= clock_reg;
        if (state_reg == psrb_pkg::S_CLEAR)
            meta_mem[clr_reg] <= '0;
        else if (state_reg == psrb_pkg::S_DONE && (found_reg || free_ok_reg))
            meta_mem[slot_reg] <= meta_wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg   <= 32'd0;
            clr_reg     <= '0;
            done        <= 1'b0;
            res         <= '0;
            id_reg      <= '0;
            slot_reg    <= '0;
            cur_reg     <= '0;
            way_reg     <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            is_new_reg  <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                psrb_pkg::S_CLEAR:
                    clr_reg <= clr_reg + 1'b1;
                psrb_pkg::S_IDLE:
                    if (start)
                    begin
                        id_reg      <= req.sender_id;
                        clock_reg   <= clock_reg + 32'(req.time_step);
                        way_reg     <= '0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        is_new_reg  <= 1'b0;
                    end
                psrb_pkg::S_MATCH:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= look_addr;
                        cur_reg   <= meta_rd;
                    end
                    else
                    begin
                        if (!meta_rd.valid && !free_ok_reg)
                        begin
                            free_ok_reg <= 1'b1;
                            slot_reg    <= look_addr;
                        end
                        way_reg <= way_reg + 1'b1;
                    end
                end
                psrb_pkg::S_PUSH:
                    if (found_reg)
                    begin
                        if (cur_reg.fill >= psrb_pkg::FILL_W'(psrb_pkg::HISTORY_DEPTH))
                            cur_reg.head <= pos_add(cur_reg.head, 7'd1);
                        else
                            cur_reg.fill <= cur_reg.fill + 7'd1;
                    end
                    else if (free_ok_reg)
                    begin
                        is_new_reg      <= 1'b1;
                        cur_reg.valid   <= 1'b1;
                        cur_reg.sender  <= id_reg;
                        cur_reg.blocked <= 1'b0;
                        cur_reg.head    <= '0;
                        cur_reg.fill    <= 7'd1;
                    end
                psrb_pkg::S_RCHK:
                    if (expired)
                    begin
                        cur_reg.head <= pos_add(cur_reg.head, 7'd1);
                        cur_reg.fill <= cur_reg.fill - 7'd1;
                    end
                psrb_pkg::S_DONE:
                begin
                    done <= 1'b1;
                    if (found_reg)
                    begin
                        cur_reg.blocked  <= blk_new;
                        res.verdict      <= blk_new ? psrb_pkg::V_BLOCKED : psrb_pkg::V_WHITE;
                        res.window_count <= cnt;
                        res.changed_list <= chg;
                    end
                    else if (is_new_reg)
                    begin
                        res.verdict      <= psrb_pkg::V_NEW;
                        res.window_count <= 7'd1;
                        res.changed_list <= 1'b0;
                    end
                    else
                    begin
                        res.verdict      <= psrb_pkg::V_FULL;
                        res.window_count <= 7'd0;
                        res.changed_list <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res.window_count <= 7'(psrb_pkg::HISTORY_DEPTH))
        else $error("window count over history depth");
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("request accepted without going busy");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for per_sender_rate_blacklist
// depends on psrb_pkg and the per_sender_rate_blacklist rtl
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE = 2 * psrb_pkg::WAYS + 2 * psrb_pkg::HISTORY_DEPTH + 64;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    psrb_pkg::req_t req;
    logic        done;
    psrb_pkg::res_t res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [30:0] cfg_data;

    per_sender_rate_blacklist uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // own copy of the sender table
    logic [30:0] window_len;
    logic [6:0]  spam_thr;
    logic [31:0] now_clk;
    logic        tbl_valid   [psrb_pkg::SLOTS];
    logic [30:0] tbl_sender  [psrb_pkg::SLOTS];
    logic        tbl_blocked [psrb_pkg::SLOTS];
    logic [31:0] tbl_stamps  [psrb_pkg::SLOTS * psrb_pkg::HISTORY_DEPTH];
    int unsigned tbl_head    [psrb_pkg::SLOTS];
    int unsigned tbl_fill    [psrb_pkg::SLOTS];

    psrb_pkg::req_t pending_msgs[$];
    psrb_pkg::res_t expected_verdicts[$];
    int   fail_count;

    task automatic report(input string what, input psrb_pkg::res_t got,
                          input psrb_pkg::res_t want);
        $display("mismatch %s: got v=%0d n=%0d c=%0d want v=%0d n=%0d c=%0d", what,
                 got.verdict, got.window_count, got.changed_list,
                 want.verdict, want.window_count, want.changed_list);
        fail_count++;
    endtask

    task automatic queue_msg(input psrb_pkg::req_t m);
        pending_msgs.insert(pending_msgs.size(), m);
    endtask

    function automatic psrb_pkg::res_t predict_verdict(input psrb_pkg::req_t m);
        psrb_pkg::res_t r;
        int unsigned first;
        int unsigned slot;
        int unsigned free_slot;
        bit          found;
        logic [31:0] age;
        begin
            r = '0;
            found = 0;
            slot = 0;
            free_slot = psrb_pkg::SLOTS;
            now_clk = now_clk + {16'd0, m.time_step};
            first = m.sender_id[psrb_pkg::BUCKET_W-1:0] * psrb_pkg::WAYS;
            for (int w = 0; w < psrb_pkg::WAYS; w++)
            begin
                if (tbl_valid[first + w])
                begin
                    if (tbl_sender[first + w] == m.sender_id && !found)
                    begin
                        found = 1;
                        slot = first + w;
                    end
                end
                else if (free_slot == psrb_pkg::SLOTS)
                    free_slot = first + w;
            end
            if (!found && free_slot == psrb_pkg::SLOTS)
            begin
                r.verdict = psrb_pkg::V_FULL;
                return r;
            end
            if (!found)
            begin
                slot = free_slot;
                tbl_valid[slot] = 1'b1;
                tbl_sender[slot] = m.sender_id;
                tbl_blocked[slot] = 1'b0;
                tbl_head[slot] = 0;
                tbl_fill[slot] = 0;
            end
            // push stamp, overwriting the oldest when the ring is full
            if (tbl_fill[slot] >= psrb_pkg::HISTORY_DEPTH)
            begin
                tbl_stamps[slot * psrb_pkg::HISTORY_DEPTH + tbl_head[slot]] = now_clk;
                tbl_head[slot] = (tbl_head[slot] + 1) % psrb_pkg::HISTORY_DEPTH;
            end
            else
            begin
                tbl_stamps[slot * psrb_pkg::HISTORY_DEPTH
                           + (tbl_head[slot] + tbl_fill[slot]) % psrb_pkg::HISTORY_DEPTH]
                    = now_clk;
                tbl_fill[slot]++;
            end
            if (!found)
            begin
                r.verdict = psrb_pkg::V_NEW;
                r.window_count = 7'd1;
                return r;
            end
            while (tbl_fill[slot] > 0)
            begin
                age = now_clk - tbl_stamps[slot * psrb_pkg::HISTORY_DEPTH + tbl_head[slot]];
                if (age <= {1'b0, window_len})
                    break;
                tbl_head[slot] = (tbl_head[slot] + 1) % psrb_pkg::HISTORY_DEPTH;
                tbl_fill[slot]--;
            end
            r.window_count = tbl_fill[slot][6:0];
            if (!tbl_blocked[slot] && r.window_count >= spam_thr)
            begin
                tbl_blocked[slot] = 1'b1;
                r.changed_list = 1'b1;
            end
            else if (tbl_blocked[slot] && r.window_count < spam_thr)
            begin
                tbl_blocked[slot] = 1'b0;
                r.changed_list = 1'b1;
            end
            r.verdict = tbl_blocked[slot] ? psrb_pkg::V_BLOCKED : psrb_pkg::V_WHITE;
            return r;
        end
    endfunction

    initial clk = 0;
    always #5 clk = ~clk;

    // driver: bursts of requests with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            req <= '0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_verdicts.insert(expected_verdicts.size(), predict_verdict(req));
                void'(pending_msgs.pop_front());
            end
            if (start && busy)
                start <= 1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 0;
            end
            else if (pending_msgs.size() > 0)
            begin
                start <= 1;
                req <= pending_msgs[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
                report("unexpected result", res, '0);
            else
            begin
                if (res.verdict !== expected_verdicts[0].verdict)
                    report("verdict", res, expected_verdicts[0]);
                if (res.window_count !== expected_verdicts[0].window_count)
                    report("window_count", res, expected_verdicts[0]);
                if (res.changed_list !== expected_verdicts[0].changed_list)
                    report("changed_list", res, expected_verdicts[0]);
                void'(expected_verdicts.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == psrb_pkg::REG_WINDOW)
            window_len = val;
        else
            spam_thr = val[6:0];
        cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        while (pending_msgs.size() > 0 || start || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic psrb_pkg::req_t mk(input logic [30:0] id, input logic [15:0] st);
        psrb_pkg::req_t m;
        m.sender_id = id;
        m.time_step = st;
        return m;
    endfunction

    // ids mostly from a small pool, a few buckets crowded past their ways
    function automatic logic [30:0] pick_sender();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 31'($urandom_range(0, 7) * 256 + $urandom_range(0, 5) * 17);
        else if (k < 8)
            return 31'($urandom_range(0, 20));
        return 31'($urandom);
    endfunction

    function automatic logic [15:0] pick_step();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return 16'($urandom_range(0, 20));
        else if (k < 8)
            return 16'($urandom_range(0, 400));
        return 16'($urandom);
    endfunction

    logic [30:0] win_set [6] = '{31'd2000, 31'd0, 31'h7fffffff, 31'd300, 31'd40, 31'd1000};
    logic [30:0] thr_set [6] = '{31'd50, 31'd1, 31'd64, 31'd0, 31'd127, 31'h7fffff85};

    initial
    begin
        fail_count = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = psrb_pkg::REG_WINDOW;
        cfg_data = '0;
        window_len = psrb_pkg::WINDOW_RESET;
        spam_thr = psrb_pkg::THRESHOLD_RESET;
        now_clk = '0;
        for (int i = 0; i < psrb_pkg::SLOTS; i++)
            tbl_valid[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes and a full bucket at default settings
        queue_msg(mk(31'd0, 16'd0));
        queue_msg(mk(31'h7fffffff, 16'hffff));
        queue_msg(mk(31'd0, 16'hffff));
        for (int k = 1; k <= 5; k++)
            queue_msg(mk(31'(5 + 256 * k), 16'd1));
        queue_msg(mk(31'h7fffff05, 16'd3));
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(psrb_pkg::REG_WINDOW, win_set[p]);
            write_reg(psrb_pkg::REG_THRESHOLD, thr_set[p]);
            // one hot sender with more requests than the ring holds, to test the threshold
            for (int i = 0; i < 70; i++)
                queue_msg(mk(31'(1000 + p), 16'($urandom_range(0, 3))));
            queue_msg(mk(31'(1000 + p), 16'hffff));
            for (int i = 0; i < 80; i++)
                queue_msg(mk(pick_sender(), pick_step()));
            wait_idle();
        end

        write_reg(psrb_pkg::REG_WINDOW, psrb_pkg::WINDOW_RESET);
        write_reg(psrb_pkg::REG_THRESHOLD, 31'd3);
        for (int i = 0; i < 80; i++)
            queue_msg(mk(pick_sender(), pick_step()));
        wait_idle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== per_sender_rate_blacklist.f =====
rtl/core/psrb_pkg.sv
rtl/core/per_sender_rate_blacklist.sv
verif/tb.sv
